FILE: hw/rtl/obrc_pkg.sv
`timescale 1ns / 1ps

package obrc_pkg;

  // Field widths of the level word and the result word
  localparam int FIELD_W     = 32;
  localparam int ZG_W        = 6;
  localparam int OS_W        = 5;
  localparam int OE_W        = 4;
  localparam int TOTAL_OUT_W = 48;
  localparam int NUM_GROUPS  = 6;

  // Saturation limits of the per-row counts
  localparam logic [ZG_W-1:0] ZgMax = '1;
  localparam logic [OS_W-1:0] OsMax = '1;
  localparam logic [OE_W-1:0] OeMax = '1;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic [ZG_W-1:0]           zg_cnt_t;
  typedef logic [OS_W-1:0]           os_cnt_t;
  typedef logic [OE_W-1:0]           oe_cnt_t;
  typedef logic [TOTAL_OUT_W-1:0]    total_out_t;

  // Finished counts of one row
  typedef struct packed {
    zg_cnt_t zero_gap;
    os_cnt_t over_size;
    oe_cnt_t order_err;
    logic    crossed;
  } row_summary_t;

endpackage

FILE: hw/rtl/obrc_ifs.sv
`timescale 1ns / 1ps

// One depth level of a snapshot row
interface obrc_level_if;
  import obrc_pkg::*;

  logic   valid;
  logic   ready;
  field_t ask_price;
  field_t bid_price;
  field_t ask_size;
  field_t bid_size;
  field_t ask_orders;
  field_t bid_orders;

  modport source (
    output valid, ask_price, bid_price, ask_size, bid_size, ask_orders, bid_orders,
    input  ready
  );
  modport sink (
    input  valid, ask_price, bid_price, ask_size, bid_size, ask_orders, bid_orders,
    output ready
  );
endinterface

// Per-row check counts and running totals
interface obrc_result_if;
  import obrc_pkg::*;

  logic       valid;
  logic       ready;
  zg_cnt_t    row_zero_gap;
  os_cnt_t    row_count_over_size;
  oe_cnt_t    row_order_errors;
  logic       row_crossed;
  total_out_t total_rows;
  total_out_t total_zero_gap;
  total_out_t total_count_over_size;
  total_out_t total_order_errors;
  total_out_t total_crossed;

  modport source (
    output valid, row_zero_gap, row_count_over_size, row_order_errors, row_crossed,
           total_rows, total_zero_gap, total_count_over_size, total_order_errors,
           total_crossed,
    input  ready
  );
  modport sink (
    input  valid, row_zero_gap, row_count_over_size, row_order_errors, row_crossed,
           total_rows, total_zero_gap, total_count_over_size, total_order_errors,
           total_crossed,
    output ready
  );
endinterface

FILE: hw/rtl/order_book_row_checker.sv
`timescale 1ns / 1ps
// After a row's last level is taken, its result word goes first into the row-end register
//   and then into the output register, where it is valid.
// Throughput: one level word per cycle unless the row-end word is blocked at the output;
//   the row-end register lets a full row keep streaming while a finished result waits at the output.
// Reset (rst, synchronous): clears the level counter, row state, totals and valids.

module order_book_row_checker #(
  parameter int LEVELS      = 8,
  parameter int TOTAL_WIDTH = 48
) (
  input  logic          clk,
  input  logic          rst,
  obrc_level_if.sink    level,
  obrc_result_if.source result
);
  import obrc_pkg::*;

  localparam int LvlW = $clog2(LEVELS);
  localparam logic [LvlW-1:0] LastLevel = LvlW'(LEVELS - 1);
  localparam logic [TOTAL_WIDTH-1:0] TotalMax = '1;

  typedef logic [TOTAL_WIDTH-1:0] total_t;

  // Saturating add of a small count into a running total
  function automatic total_t sat_total(total_t t, zg_cnt_t n);
    logic [TOTAL_WIDTH:0] s;
    s = {1'b0, t} + (TOTAL_WIDTH+1)'(n);
    return s[TOTAL_WIDTH] ? TotalMax : s[TOTAL_WIDTH-1:0];
  endfunction

  // Row state
  logic [LvlW-1:0]       level_index;
  logic [NUM_GROUPS-1:0] seen_zero;
  field_t                prev_ask;
  field_t                prev_bid;
  zg_cnt_t               zg_acc;
  os_cnt_t               os_acc;
  oe_cnt_t               oe_acc;
  logic                  crossed_flag;

  // Row-end register and totals
  logic         done_valid;
  row_summary_t done_row;
  total_t       tot_rows, tot_zg, tot_os, tot_oe, tot_cr;

  logic                  accept, last_level, out_free, move;
  logic [NUM_GROUPS-1:0] is_zero;
  logic [2:0]            gaps;
  logic [1:0]            over, ord;
  logic [ZG_W:0]         zg_sum;
  logic [OS_W:0]         os_sum;
  logic [OE_W:0]         oe_sum;
  logic                  crossed_next;
  row_summary_t          row_next;

  assign out_free    = !result.valid || result.ready;
  assign move        = done_valid && out_free;
  assign level.ready = !done_valid || out_free;
  assign accept      = level.valid && level.ready;
  assign last_level  = (level_index == LastLevel);

  // Evaluate the four checks on the incoming level
  always_comb begin
    is_zero = {level.bid_orders == '0, level.ask_orders == '0, level.bid_size == '0,
               level.ask_size == '0, level.bid_price == '0, level.ask_price == '0};
    gaps = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      gaps = gaps + 3'(!is_zero[g] && seen_zero[g]);
    end
    over = 2'(level.ask_orders > level.ask_size) + 2'(level.bid_orders > level.bid_size);
    ord = '0;
    crossed_next = crossed_flag;
    if (level_index == '0) begin
      if (!is_zero[0] && !is_zero[1] && level.ask_price < level.bid_price) begin
        crossed_next = 1'b1;
      end
    end else begin
      ord = 2'(!is_zero[0] && prev_ask != '0 && level.ask_price <= prev_ask)
          + 2'(!is_zero[1] && prev_bid != '0 && level.bid_price >= prev_bid);
    end
    zg_sum = {1'b0, zg_acc} + (ZG_W+1)'(gaps);
    os_sum = {1'b0, os_acc} + (OS_W+1)'(over);
    oe_sum = {1'b0, oe_acc} + (OE_W+1)'(ord);
    row_next.zero_gap  = zg_sum[ZG_W] ? ZgMax : zg_sum[ZG_W-1:0];
    row_next.over_size = os_sum[OS_W] ? OsMax : os_sum[OS_W-1:0];
    row_next.order_err = oe_sum[OE_W] ? OeMax : oe_sum[OE_W-1:0];
    row_next.crossed   = crossed_next;
  end

  // Advance row state; clear it at the row's last level
  always_ff @(posedge clk) begin
    if (rst) begin
      level_index  <= '0;
      seen_zero    <= '0;
      prev_ask     <= '0;
      prev_bid     <= '0;
      zg_acc       <= '0;
      os_acc       <= '0;
      oe_acc       <= '0;
      crossed_flag <= 1'b0;
    end else if (accept) begin
      if (last_level) begin
        level_index  <= '0;
        seen_zero    <= '0;
        prev_ask     <= '0;
        prev_bid     <= '0;
        zg_acc       <= '0;
        os_acc       <= '0;
        oe_acc       <= '0;
        crossed_flag <= 1'b0;
      end else begin
        level_index  <= level_index + 1'b1;
        seen_zero    <= seen_zero | is_zero;
        prev_ask     <= level.ask_price;
        prev_bid     <= level.bid_price;
        zg_acc       <= row_next.zero_gap;
        os_acc       <= row_next.over_size;
        oe_acc       <= row_next.order_err;
        crossed_flag <= row_next.crossed;
      end
    end
  end

  // Hold the finished row until the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      done_valid <= 1'b0;
    end else if (accept && last_level) begin
      done_valid <= 1'b1;
    end else if (move) begin
      done_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_level) begin
      done_row <= row_next;
    end
  end

  // Update totals and load the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      tot_rows     <= '0;
      tot_zg       <= '0;
      tot_os       <= '0;
      tot_oe       <= '0;
      tot_cr       <= '0;
    end else if (move) begin
      result.valid <= 1'b1;
      tot_rows     <= sat_total(tot_rows, ZG_W'(1));
      tot_zg       <= sat_total(tot_zg, done_row.zero_gap);
      tot_os       <= sat_total(tot_os, ZG_W'(done_row.over_size));
      tot_oe       <= sat_total(tot_oe, ZG_W'(done_row.order_err));
      tot_cr       <= sat_total(tot_cr, ZG_W'(done_row.crossed));
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result.row_zero_gap        <= done_row.zero_gap;
      result.row_count_over_size <= done_row.over_size;
      result.row_order_errors    <= done_row.order_err;
      result.row_crossed         <= done_row.crossed;
    end
  end

  always_comb begin
    result.total_rows            = TOTAL_OUT_W'(tot_rows);
    result.total_zero_gap        = TOTAL_OUT_W'(tot_zg);
    result.total_count_over_size = TOTAL_OUT_W'(tot_os);
    result.total_order_errors    = TOTAL_OUT_W'(tot_oe);
    result.total_crossed         = TOTAL_OUT_W'(tot_cr);
  end

  // A level that is not the last never starts a row-end word
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (accept && !last_level && !done_valid) |=> !done_valid)
    else $error("row-end word raised before the last level");

  // The row counter steps by one at most, or holds at saturation
  a_rows_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (tot_rows == $past(tot_rows) || tot_rows == $past(tot_rows) + 1'b1))
    else $error("row total jumped");

  // Input stalls only while a finished row is blocked by a full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !level.ready |-> (done_valid && result.valid && !result.ready))
    else $error("input stalled without a blocked result");

  // A new row-end word always finds the row state cleared
  a_row_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(done_valid) |-> (level_index == '0 && seen_zero == '0 && zg_acc == '0))
    else $error("row state not cleared at row end");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import obrc_pkg::*;

  localparam int ROW_LEVELS  = 8;
  localparam int TOTAL_W     = 48;
  localparam int IDLE_PCT    = 37;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 60000;
  localparam logic [63:0] TOT_MAX = (64'd1 << TOTAL_W) - 1;

  typedef struct {
    field_t ask_price;
    field_t bid_price;
    field_t ask_size;
    field_t bid_size;
    field_t ask_orders;
    field_t bid_orders;
  } book_level_t;

  typedef struct {
    zg_cnt_t     zero_gap;
    os_cnt_t     over_size;
    oe_cnt_t     order_err;
    logic        crossed;
    logic [63:0] rows;
    logic [63:0] gap_total;
    logic [63:0] over_total;
    logic [63:0] order_total;
    logic [63:0] crossed_total;
  } row_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  obrc_level_if  lvl_bus ();
  obrc_result_if res_bus ();

  order_book_row_checker #(
    .LEVELS      (ROW_LEVELS),
    .TOTAL_WIDTH (TOTAL_W)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .level  (lvl_bus),
    .result (res_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectations
  book_level_t levels_pending[$];
  row_report_t reports_due[$];
  int          levels_queued  = 0;
  int          levels_taken   = 0;
  int          reports_seen   = 0;
  int          crossed_seen   = 0;
  int          err_count      = 0;
  int          cycle_count    = 0;
  logic        lvl_fire       = 1'b0;
  logic        calm           = 1'b0;
  logic        hold_go        = 1'b0;

  // Running copy of the row checker state
  int          row_level   = 0;
  logic [5:0]  zero_seen   = '0;
  field_t      prev_ask    = '0;
  field_t      prev_bid    = '0;
  zg_cnt_t     acc_gap     = '0;
  os_cnt_t     acc_over    = '0;
  oe_cnt_t     acc_order   = '0;
  logic        top_crossed = 1'b0;
  logic [63:0] tot_rows    = '0;
  logic [63:0] tot_gap     = '0;
  logic [63:0] tot_over    = '0;
  logic [63:0] tot_order   = '0;
  logic [63:0] tot_crossed = '0;

  function automatic logic [63:0] sat_total(logic [63:0] t, logic [63:0] n);
    if (n > TOT_MAX - t) return TOT_MAX;
    return t + n;
  endfunction

  // Fold one level word into the row state; queue a report at row end
  task automatic absorb_level(input book_level_t w);
    field_t      v [NUM_GROUPS];
    int          g;
    int          gaps;
    int          over;
    int          ord;
    int          s;
    row_report_t rep;
    v[0] = w.ask_price;
    v[1] = w.bid_price;
    v[2] = w.ask_size;
    v[3] = w.bid_size;
    v[4] = w.ask_orders;
    v[5] = w.bid_orders;
    gaps = 0;
    over = 0;
    ord  = 0;
    for (g = 0; g < NUM_GROUPS; g++) begin
      if (v[g] == 0) zero_seen[g] = 1'b1;
      else if (zero_seen[g]) gaps++;
    end
    if (w.ask_orders > w.ask_size) over++;
    if (w.bid_orders > w.bid_size) over++;
    if (row_level == 0) begin
      if (w.ask_price != 0 && w.bid_price != 0 && w.ask_price < w.bid_price)
        top_crossed = 1'b1;
    end else begin
      if (w.ask_price != 0 && prev_ask != 0 && w.ask_price <= prev_ask) ord++;
      if (w.bid_price != 0 && prev_bid != 0 && w.bid_price >= prev_bid) ord++;
    end
    prev_ask = w.ask_price;
    prev_bid = w.bid_price;
    s = int'(acc_gap) + gaps;
    acc_gap = (s > int'(ZgMax)) ? ZgMax : zg_cnt_t'(s);
    s = int'(acc_over) + over;
    acc_over = (s > int'(OsMax)) ? OsMax : os_cnt_t'(s);
    s = int'(acc_order) + ord;
    acc_order = (s > int'(OeMax)) ? OeMax : oe_cnt_t'(s);

    if (row_level + 1 < ROW_LEVELS) begin
      row_level++;
    end else begin
      tot_rows    = sat_total(tot_rows, 64'd1);
      tot_gap     = sat_total(tot_gap, 64'(acc_gap));
      tot_over    = sat_total(tot_over, 64'(acc_over));
      tot_order   = sat_total(tot_order, 64'(acc_order));
      tot_crossed = sat_total(tot_crossed, 64'(top_crossed));
      rep.zero_gap      = acc_gap;
      rep.over_size     = acc_over;
      rep.order_err     = acc_order;
      rep.crossed       = top_crossed;
      rep.rows          = tot_rows;
      rep.gap_total     = tot_gap;
      rep.over_total    = tot_over;
      rep.order_total   = tot_order;
      rep.crossed_total = tot_crossed;
      reports_due.push_back(rep);
      row_level   = 0;
      zero_seen   = '0;
      prev_ask    = '0;
      prev_bid    = '0;
      acc_gap     = '0;
      acc_over    = '0;
      acc_order   = '0;
      top_crossed = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_count++;
    end
  endtask

  // Sample both handshakes at the rising edge and check each result word
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      lvl_fire = !rst && lvl_bus.valid && lvl_bus.ready;
      if (lvl_fire) begin
        absorb_level('{lvl_bus.ask_price, lvl_bus.bid_price, lvl_bus.ask_size,
                       lvl_bus.bid_size, lvl_bus.ask_orders, lvl_bus.bid_orders});
        levels_taken++;
      end
      if (!rst && res_bus.valid && res_bus.ready) begin
        reports_seen++;
        if (res_bus.row_crossed) crossed_seen++;
        if (reports_due.size() == 0) begin
          $error("result word with no row report pending");
          err_count++;
        end else begin
          row_report_t rep;
          rep = reports_due.pop_front();
          check_field("row_zero_gap", 64'(rep.zero_gap), 64'(res_bus.row_zero_gap));
          check_field("row_count_over_size", 64'(rep.over_size),
                      64'(res_bus.row_count_over_size));
          check_field("row_order_errors", 64'(rep.order_err),
                      64'(res_bus.row_order_errors));
          check_field("row_crossed", 64'(rep.crossed), 64'(res_bus.row_crossed));
          check_field("total_rows", 64'(rep.rows[TOTAL_OUT_W-1:0]),
                      64'(res_bus.total_rows));
          check_field("total_zero_gap", 64'(rep.gap_total[TOTAL_OUT_W-1:0]),
                      64'(res_bus.total_zero_gap));
          check_field("total_count_over_size", 64'(rep.over_total[TOTAL_OUT_W-1:0]),
                      64'(res_bus.total_count_over_size));
          check_field("total_order_errors", 64'(rep.order_total[TOTAL_OUT_W-1:0]),
                      64'(res_bus.total_order_errors));
          check_field("total_crossed", 64'(rep.crossed_total[TOTAL_OUT_W-1:0]),
                      64'(res_bus.total_crossed));
        end
      end
    end
  end

  // Drive level words: advance on acceptance, idle at random unless calm
  always @(negedge clk) begin
    book_level_t w;
    if (rst) begin
      lvl_bus.valid <= 1'b0;
    end else if (!lvl_bus.valid || lvl_fire) begin
      if (levels_pending.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        w = levels_pending.pop_front();
        lvl_bus.ask_price  <= w.ask_price;
        lvl_bus.bid_price  <= w.bid_price;
        lvl_bus.ask_size   <= w.ask_size;
        lvl_bus.bid_size   <= w.bid_size;
        lvl_bus.ask_orders <= w.ask_orders;
        lvl_bus.bid_orders <= w.bid_orders;
        lvl_bus.valid      <= 1'b1;
      end else begin
        lvl_bus.valid <= 1'b0;
      end
    end
  end

  // Result ready: one long hold-off, then random stalls unless calm
  int   hold_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_bus.ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      res_bus.ready <= 1'b0;
    end else if (calm) begin
      res_bus.ready <= 1'b1;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic queue_level(input field_t ap, input field_t bp, input field_t as_v,
                             input field_t bs_v, input field_t ao, input field_t bo);
    levels_pending.push_back('{ap, bp, as_v, bs_v, ao, bo});
    levels_queued++;
  endtask

  function automatic field_t pick_field();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'sh7fffffff;
      2:       return 32'sh80000000;
      3:       return -32'sd1;
      default: return field_t'($urandom);
    endcase
  endfunction

  // Mostly well-formed books with random depth and content, some corrupted, some noise
  task automatic queue_random_row();
    int          kind;
    int          ask_depth;
    int          bid_depth;
    int          l;
    int unsigned sz;
    field_t      mid;
    field_t      ask_p;
    field_t      bid_p;
    field_t      tmp;
    book_level_t w;
    kind      = $urandom_range(0, 99);
    ask_depth = ($urandom_range(0, 3) != 0) ? ROW_LEVELS : $urandom_range(0, ROW_LEVELS);
    bid_depth = ($urandom_range(0, 3) != 0) ? ROW_LEVELS : $urandom_range(0, ROW_LEVELS);
    mid   = field_t'($urandom_range(0, 2000000000)) - 32'sd1000000000;
    ask_p = mid + field_t'($urandom_range(0, 50));
    bid_p = mid - field_t'($urandom_range(1, 50));
    for (l = 0; l < ROW_LEVELS; l++) begin
      if (kind < 15) begin
        w = '{pick_field(), pick_field(), pick_field(), pick_field(), pick_field(),
              pick_field()};
      end else begin
        w.ask_price = (l < ask_depth) ? ask_p : '0;
        w.bid_price = (l < bid_depth) ? bid_p : '0;
        sz = $urandom_range(1, 100000);
        w.ask_size   = (l < ask_depth) ? field_t'(sz) : '0;
        w.ask_orders = (l < ask_depth) ? field_t'($urandom_range(0, sz)) : '0;
        sz = $urandom_range(1, 100000);
        w.bid_size   = (l < bid_depth) ? field_t'(sz) : '0;
        w.bid_orders = (l < bid_depth) ? field_t'($urandom_range(0, sz)) : '0;
        ask_p = ask_p + field_t'($urandom_range(1, 1000));
        bid_p = bid_p - field_t'($urandom_range(1, 1000));
        // cross the top of book on some rows
        if (l == 0 && kind < 25) begin
          tmp = w.ask_price;
          w.ask_price = w.bid_price;
          w.bid_price = tmp;
        end
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 5))
            0: w.ask_price  = '0;
            1: w.bid_price  = w.bid_price + 32'sd2000;
            2: w.ask_orders = w.ask_size + 32'sd1;
            3: w.bid_orders = pick_field();
            4: w.ask_size   = '0;
            default: w.ask_price = w.ask_price - 32'sd2000;
          endcase
        end
      end
      queue_level(w.ask_price, w.bid_price, w.ask_size, w.bid_size, w.ask_orders,
                  w.bid_orders);
    end
  endtask

  // Hold the sender until every queued word is taken and every report has come
  task automatic wait_drained();
    while (levels_taken != levels_queued || reports_due.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int l;
    int r;
    lvl_bus.valid      = 1'b0;
    lvl_bus.ask_price  = '0;
    lvl_bus.bid_price  = '0;
    lvl_bus.ask_size   = '0;
    lvl_bus.bid_size   = '0;
    lvl_bus.ask_orders = '0;
    lvl_bus.bid_orders = '0;
    res_bus.ready      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Clean book with extreme prices at the deepest level, extreme ask sizes and top bid orders
    for (l = 0; l < ROW_LEVELS; l++)
      queue_level((l == ROW_LEVELS - 1) ? 32'sh7fffffff : field_t'(100 + l),
                  (l == ROW_LEVELS - 1) ? 32'sh80000000 : field_t'(99 - l),
                  32'sh7fffffff, 32'sd1000, field_t'(l),
                  (l == 0) ? 32'sh80000000 : 32'sd1000);
    // Crossed top, equal prices, zero gaps, negative sizes with counts over them
    queue_level(32'sd5, 32'sd10, 32'sh80000000, -32'sd2, 32'sh7fffffff, -32'sd1);
    queue_level(32'sd5, 32'sd10, '0, '0, '0, '0);
    queue_level('0, '0, 32'sd7, 32'sd7, 32'sd1, 32'sd8);
    queue_level(32'sd3, -32'sd1, '0, '0, '0, '0);
    queue_level(32'sd2, 32'sd4, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
    for (l = 5; l < ROW_LEVELS; l++)
      queue_level(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
    // Empty book apart from a lone negative ask on top and a full last level
    queue_level(-32'sd5, '0, '0, '0, '0, '0);
    for (l = 1; l < ROW_LEVELS - 1; l++)
      queue_level('0, '0, '0, '0, '0, '0);
    queue_level(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                32'sh7fffffff, 32'sh7fffffff);
    wait_drained();

    // Random rows under a long result hold-off that backs up the input
    hold_go = 1'b1;
    for (r = 0; r < 22; r++) queue_random_row();
    wait_drained();

    // Back-to-back stretch with no idling on either side
    calm = 1'b1;
    for (r = 0; r < 22; r++) queue_random_row();
    wait_drained();
    calm = 1'b0;

    for (r = 0; r < 22; r++) queue_random_row();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d level words in, %0d row reports checked (%0d crossed tops)",
             levels_taken, reports_seen, crossed_seen);
    $display("tb: covered field extremes, noise rows, result hold-off and drain pauses");
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
